>>> src/sbte_pkg.sv
// Package for the six-bit text encoder: result types and shared constants.
// Used by sbte_encode, sbte_outq and six_bit_text_encoder; depends on nothing.
package sbte_pkg;

    localparam int unsigned COUNT_BITS_DEFAULT = 16;
    localparam int unsigned SYM_BITS           = 6;
    localparam logic [7:0]  SYM_OFFSET         = 8'h3C;
    localparam logic [15:0] DEST_LIMIT_RESET   = 16'd1024;

    // One result item as it leaves the block.
    typedef struct packed {
        logic [7:0]  symbol;
        logic        has_symbol;
        logic        end_of_run;
        logic [15:0] total_length;
    } result_t;

    // The results caused by one input item: count of valid slots, then slots.
    typedef struct packed {
        logic [1:0]        count;
        result_t [1:0]     res;
    } pair_t;

endpackage

>>> src/sbte_encode.sv
// Encoding step: holds the leftover bits, phase and symbol count and turns
// one source byte into up to two results. Depends on sbte_pkg.
module sbte_encode #(
    parameter int unsigned COUNT_BITS = sbte_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  logic [7:0]          src_byte,
    input  logic                is_last,
    input  logic [15:0]         dest_limit,
    output sbte_pkg::pair_t     pair
);

    localparam int unsigned CW = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam logic [CW-1:0] COUNT_MAX = CW'({COUNT_BITS{1'b1}});

    localparam logic [1:0] PH_NONE = 2'd0;
    localparam logic [1:0] PH_TWO  = 2'd1;
    localparam logic [1:0] PH_FOUR = 2'd2;

    localparam int unsigned SB = sbte_pkg::SYM_BITS;

    logic [SB-1:0]         leftover_reg, leftover_next;
    logic [1:0]            phase_reg, phase_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;

    logic [CW-1:0] lim;
    logic [CW-1:0] cnt_w;
    logic [CW-1:0] cnt1;
    logic [CW-1:0] cnt_n;
    logic [SB-1:0] made;
    logic [SB-1:0] rest;
    logic [SB-1:0] sym0;
    logic [SB-1:0] sym1;
    logic [SB-1:0] left_n;
    logic [1:0]    ph_after;
    logic [1:0]    ph_n;
    logic          wrap;
    logic [1:0]    n;
    logic [15:0]   total;

    always_comb begin
        lim   = (CW'(dest_limit) < COUNT_MAX) ? CW'(dest_limit) : COUNT_MAX;
        cnt_w = CW'(count_reg);
        cnt1  = cnt_w + CW'(1);
        wrap  = 1'b0;

        case (phase_reg)
            PH_NONE: begin
                made     = src_byte[7:2];
                rest     = {src_byte[1:0], 4'b0000};
                ph_after = PH_TWO;
            end
            PH_TWO: begin
                made     = leftover_reg | {2'b00, src_byte[7:4]};
                rest     = {src_byte[3:0], 2'b00};
                ph_after = PH_FOUR;
            end
            default: begin
                made     = leftover_reg | {4'b0000, src_byte[7:6]};
                rest     = src_byte[5:0];
                ph_after = PH_NONE;
                wrap     = 1'b1;
            end
        endcase

        sym0   = '0;
        sym1   = '0;
        n      = 2'd0;
        left_n = leftover_reg;
        ph_n   = phase_reg;
        cnt_n  = cnt_w;

        if (cnt_w < lim) begin
            sym0 = made;
            n    = 2'd1;
            if (wrap) begin
                left_n = '0;
                ph_n   = PH_NONE;
                if (cnt1 < lim) begin
                    sym1  = rest;
                    n     = 2'd2;
                    cnt_n = cnt1 + CW'(1);
                end else begin
                    cnt_n = cnt1;
                end
            end else begin
                left_n = rest;
                ph_n   = ph_after;
                cnt_n  = cnt1;
            end
        end

        // The last byte flushes pending bits when a symbol still fits.
        if (is_last && ph_n != PH_NONE && cnt_n < lim && n != 2'd2) begin
            if (n == 2'd0) begin
                sym0 = left_n;
                n    = 2'd1;
            end else begin
                sym1 = left_n;
                n    = 2'd2;
            end
            cnt_n = cnt_n + CW'(1);
        end

        total = cnt_n[15:0];

        pair = '0;
        if (is_last && n == 2'd0) begin
            pair.count                  = 2'd1;
            pair.res[0].end_of_run      = 1'b1;
            pair.res[0].total_length    = total;
        end else begin
            pair.count                  = n;
            pair.res[0].symbol          = {2'b00, sym0} + sbte_pkg::SYM_OFFSET;
            pair.res[0].has_symbol      = 1'b1;
            pair.res[0].end_of_run      = (n == 2'd1);
            pair.res[0].total_length    = (n == 2'd1 && is_last) ? total : 16'd0;
            pair.res[1].symbol          = {2'b00, sym1} + sbte_pkg::SYM_OFFSET;
            pair.res[1].has_symbol      = 1'b1;
            pair.res[1].end_of_run      = 1'b1;
            pair.res[1].total_length    = is_last ? total : 16'd0;
        end

        if (is_last) begin
            leftover_next = '0;
            phase_next    = PH_NONE;
            count_next    = '0;
        end else begin
            leftover_next = left_n;
            phase_next    = ph_n;
            count_next    = cnt_n[COUNT_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            leftover_reg <= '0;
            phase_reg    <= PH_NONE;
            count_reg    <= '0;
        end else if (advance) begin
            leftover_reg <= leftover_next;
            phase_reg    <= phase_next;
            count_reg    <= count_next;
        end
    end

    a_phase_code: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != 2'd3)
        else $error("sbte_encode: unused phase code reached");

    a_no_stale_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_NONE |-> leftover_reg == '0)
        else $error("sbte_encode: leftover bits held with no phase");

endmodule

>>> src/sbte_outq.sv
// Result buffer: holds the up to two results of one item and hands them out
// one per handshake. Depends on sbte_pkg.
module sbte_outq (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  sbte_pkg::pair_t     pair,
    output logic                can_load,
    output logic                m_valid,
    input  logic                m_ready,
    output sbte_pkg::result_t   m_result
);

    logic              v0_reg, v1_reg;
    sbte_pkg::result_t slot0_reg, slot1_reg;
    logic              take;

    assign m_valid  = v0_reg | v1_reg;
    assign m_result = v0_reg ? slot0_reg : slot1_reg;
    assign take     = m_valid & m_ready;
    // Free after this cycle when empty or when the one remaining result leaves.
    assign can_load = !m_valid || (m_ready && !(v0_reg && v1_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end else if (load) begin
            v0_reg <= (pair.count != 2'd0);
            v1_reg <= (pair.count == 2'd2);
        end else if (take) begin
            if (v0_reg) begin
                v0_reg <= 1'b0;
            end else begin
                v1_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            slot0_reg <= pair.res[0];
            slot1_reg <= pair.res[1];
        end
    end

    a_first_not_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (v0_reg && v1_reg) |-> !slot0_reg.end_of_run)
        else $error("sbte_outq: first of two results marked as end of run");

    a_count_only_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_result.has_symbol) |-> m_result.end_of_run)
        else $error("sbte_outq: count-only result without end of run");

    a_total_on_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_result.end_of_run) |-> m_result.total_length == 16'd0)
        else $error("sbte_outq: total length outside the final result");

endmodule

>>> src/six_bit_text_encoder.sv
// Top level of the six-bit text encoder: input register, configuration
// register and the instances of sbte_encode and sbte_outq. Depends on sbte_pkg.
//
// Usage:
// Source bytes enter on the s_ channel (s_src_byte, s_is_last) with a
// valid/ready handshake. Every three bytes become four symbols, each a six-bit
// value plus 0x3C, sent on the m_ channel one result item per handshake.
// s_is_last marks the final byte of a message: pending bits are flushed as a
// symbol if the limit allows, and the final result of that item carries the
// message's symbol count in m_total_length. If the item made no symbol, it
// still gives one count-only item with m_has_symbol low.
// The cfg_ channel writes dest_limit, the maximum number of symbols per
// message; it is always ready and should be written only while the block is idle.
// m_valid rises once an accepted byte has moved from the input register into the
// result buffer. With m_ready held high one byte is accepted every cycle while
// each byte gives at most one result; a byte that completes a group, or a final
// byte that flushes pending bits, can give two results and then holds the result
// buffer until both have left. When m_ready is low the result buffer and then the
// input register fill, and s_ready drops; nothing is lost. Reset clears the encoder
// state, sets dest_limit to 1024 and empties both registers.
module six_bit_text_encoder #(
    parameter int unsigned COUNT_BITS = sbte_pkg::COUNT_BITS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_src_byte,
    input  logic        s_is_last,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_symbol,
    output logic        m_has_symbol,
    output logic        m_end_of_run,
    output logic [15:0] m_total_length,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic              in_valid_reg;
    logic [7:0]        byte_reg;
    logic              last_reg;
    logic [15:0]       dest_limit_reg;
    logic              can_load;
    logic              advance;
    sbte_pkg::pair_t   pair;
    sbte_pkg::result_t result;

    // An item moves from the input register into the encoder when the
    // result buffer will be free at this edge.
    assign advance   = in_valid_reg & can_load;
    assign s_ready   = !in_valid_reg || can_load;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            dest_limit_reg <= sbte_pkg::DEST_LIMIT_RESET;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                dest_limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_src_byte;
            last_reg <= s_is_last;
        end
    end

    sbte_encode #(
        .COUNT_BITS (COUNT_BITS)
    ) u_encode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .src_byte   (byte_reg),
        .is_last    (last_reg),
        .dest_limit (dest_limit_reg),
        .pair       (pair)
    );

    sbte_outq u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .pair     (pair),
        .can_load (can_load),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (result)
    );

    assign m_symbol       = result.symbol;
    assign m_has_symbol   = result.has_symbol;
    assign m_end_of_run   = result.end_of_run;
    assign m_total_length = result.total_length;

endmodule
